FILE: hw/rtl/prsv_pkg.sv
// ----------------------------------------------------------------------------
// prsv_pkg
// Shared types and constants of the rectangle set validator.
// ----------------------------------------------------------------------------
package prsv_pkg;

   localparam int unsigned ALIGN_BITS         = 3;
   localparam int unsigned PANEL_WIDTH_RESET  = 800;
   localparam int unsigned PANEL_HEIGHT_RESET = 480;

   localparam logic CSR_PANEL_WIDTH  = 1'b0;
   localparam logic CSR_PANEL_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      RECT_OK      = 2'd0,
      RECT_BAD     = 2'd1,
      RECT_OVERLAP = 2'd2,
      RECT_FULL    = 2'd3
   } rect_status_type;

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic finish;
   } prsv_cmd_type;

   typedef struct packed {
      logic bad;
      logic empty;
      logic scan_done;
      logic out_free;
   } prsv_stat_type;

endpackage

FILE: hw/rtl/prsv_ram.sv
// ----------------------------------------------------------------------------
// prsv_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module prsv_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/prsv_datapath.sv
// ----------------------------------------------------------------------------
// prsv_datapath
// Panel registers, rectangle checks, table scan and result register.
// ----------------------------------------------------------------------------
module prsv_datapath
   import prsv_pkg::*;
#(
   parameter int unsigned MAX_RECTS  = 16,
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata,
   input  logic [COORD_BITS-1:0] req_rect_x,
   input  logic [COORD_BITS-1:0] req_rect_y,
   input  logic [COORD_BITS-1:0] req_rect_width,
   input  logic [COORD_BITS-1:0] req_rect_height,
   input  logic                  req_last_rect,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_rect_status,
   output logic                  rsp_set_valid,
   output logic                  rsp_set_done,
   input  prsv_cmd_type          cmd,
   output prsv_stat_type         stat
);

   localparam int unsigned AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int unsigned CW = $clog2(MAX_RECTS + 1);
   localparam int unsigned EW = 4 * COORD_BITS;

   logic [COORD_BITS-1:0] pw_ff, ph_ff;
   logic [COORD_BITS-1:0] x_ff, y_ff, w_ff, h_ff;
   logic                  last_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic                  ok_ff, ok_in;
   logic [CW-1:0]         idx_ff;
   logic                  pend_ff, pend_last_ff;
   logic                  hit_ff;
   logic                  rsp_valid_ff;
   rect_status_type       rsp_status_ff;
   logic                  rsp_set_valid_ff, rsp_set_done_ff;

   logic                  issue;
   logic [EW-1:0]         rd_data;
   logic [COORD_BITS-1:0] ex, ey, ew, eh;
   logic                  overlap;
   logic                  bad;
   rect_status_type       verdict;
   logic                  wr_en;

   // shape and bounds check
   always_comb begin
      bad = (w_ff == '0) || (h_ff == '0)
         || (x_ff[ALIGN_BITS-1:0] != '0) || (w_ff[ALIGN_BITS-1:0] != '0)
         || (x_ff >= pw_ff) || (y_ff >= ph_ff)
         || (w_ff > (pw_ff - x_ff)) || (h_ff > (ph_ff - y_ff));
   end

   assign issue = cmd.scan_step && (idx_ff < count_ff);

   prsv_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_RECTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({x_ff, y_ff, w_ff, h_ff}),
      .rd_en   (issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign {ex, ey, ew, eh} = rd_data;

   // half-open intervals, shared edges do not overlap
   always_comb begin
      overlap = ({1'b0, x_ff} < ({1'b0, ex} + {1'b0, ew}))
         && ({1'b0, ex} < ({1'b0, x_ff} + {1'b0, w_ff}))
         && ({1'b0, y_ff} < ({1'b0, ey} + {1'b0, eh}))
         && ({1'b0, ey} < ({1'b0, y_ff} + {1'b0, h_ff}));
   end

   always_comb begin
      if (bad) begin
         verdict = RECT_BAD;
      end else if (hit_ff) begin
         verdict = RECT_OVERLAP;
      end else if (count_ff >= CW'(MAX_RECTS)) begin
         verdict = RECT_FULL;
      end else begin
         verdict = RECT_OK;
      end
   end

   assign wr_en    = cmd.finish && (verdict == RECT_OK);
   assign ok_in    = ok_ff && (verdict == RECT_OK);
   assign count_in = wr_en ? count_ff + CW'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff <= COORD_BITS'(PANEL_WIDTH_RESET);
         ph_ff <= COORD_BITS'(PANEL_HEIGHT_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PANEL_WIDTH:  pw_ff <= csr_wdata;
            CSR_PANEL_HEIGHT: ph_ff <= csr_wdata;
            default:          pw_ff <= pw_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff    <= req_rect_x;
         y_ff    <= req_rect_y;
         w_ff    <= req_rect_width;
         h_ff    <= req_rect_height;
         last_ff <= req_last_rect;
      end
      if (issue) begin
         pend_last_ff <= ((idx_ff + CW'(1)) == count_ff);
      end
      if (cmd.finish) begin
         rsp_status_ff    <= verdict;
         rsp_set_valid_ff <= ok_in;
         rsp_set_done_ff  <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ok_ff        <= 1'b1;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            idx_ff  <= '0;
            pend_ff <= 1'b0;
            hit_ff  <= 1'b0;
         end else begin
            pend_ff <= issue;
            if (issue) begin
               idx_ff <= idx_ff + CW'(1);
            end
            if (pend_ff && overlap) begin
               hit_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            count_ff <= last_ff ? '0 : count_in;
            ok_ff    <= last_ff ? 1'b1 : ok_in;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.bad       = bad;
   assign stat.empty     = (count_ff == '0);
   assign stat.scan_done = pend_ff && (overlap || pend_last_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rect_status = rsp_status_ff;
   assign rsp_set_valid   = rsp_set_valid_ff;
   assign rsp_set_done    = rsp_set_done_ff;

endmodule

FILE: hw/rtl/prsv_ctrl.sv
// ----------------------------------------------------------------------------
// prsv_ctrl
// Sequencer: accept, check, table scan, result hand-off.
// ----------------------------------------------------------------------------
module prsv_ctrl
   import prsv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output prsv_cmd_type  cmd,
   input  prsv_stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= ST_CHECK;
                  ready_ff <= 1'b0;
               end
            end
            ST_CHECK: begin
               if (stat.bad || stat.empty) begin
                  state_ff <= ST_RESULT;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (stat.scan_done) begin
                  state_ff <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (stat.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready     = ready_ff;
   assign cmd.capture   = req_valid && ready_ff;
   assign cmd.scan_step = (state_ff == ST_CHECK) || (state_ff == ST_SCAN);
   assign cmd.finish    = (state_ff == ST_RESULT) && stat.out_free;

endmodule

FILE: hw/rtl/partial_rect_set_validator.sv
// ----------------------------------------------------------------------------
// partial_rect_set_validator
// Checks display update rectangles against the panel and the current set.
//
// Rectangles arrive on the req_ channel (valid/ready) and each one yields one
// result on the rsp_ channel: status, sticky set-valid flag, set-done echo.
// The user must write panel width and height on the csr_ port (index 0 and 1)
// only while the block is idle; the block itself does not enforce this.
// Steps: the rectangle is taken, a bounds check state follows, then the stored
// rectangles of the set are scanned (the table RAM read port is scanned one
// entry a cycle, stopping at the first overlap), then a result state hands
// the result off. A bad rectangle, or one checked against an empty table,
// skips the scan and goes from the check state to the result state.
// A result waits in its output register while the receiver stalls; the next
// rectangle is taken meanwhile, and its own result then waits for the slot.
// Reset empties the set, sets the set-valid flag and loads panel 800 x 480.
// ----------------------------------------------------------------------------
module partial_rect_set_validator
   import prsv_pkg::*;
#(
   parameter int unsigned MAX_RECTS  = 16,
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_rect_x,
   input  logic [COORD_BITS-1:0] req_rect_y,
   input  logic [COORD_BITS-1:0] req_rect_width,
   input  logic [COORD_BITS-1:0] req_rect_height,
   input  logic                  req_last_rect,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_rect_status,
   output logic                  rsp_set_valid,
   output logic                  rsp_set_done
);

   prsv_cmd_type  cmd;
   prsv_stat_type stat;

   prsv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   prsv_datapath #(
      .MAX_RECTS  (MAX_RECTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_last_rect   (req_last_rect),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_rect_status (rsp_rect_status),
      .rsp_set_valid   (rsp_set_valid),
      .rsp_set_done    (rsp_set_done),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule
